// ===== design/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the Base64 encoder.
package b64e_pkg;

  localparam int CHAR_W    = 7;
  localparam int MAX_CHARS = 4;
  localparam int IDX_W     = $clog2(MAX_CHARS);
  localparam int Q_DEPTH   = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
  } out_item_t;

  // One encoded request: up to four characters, index of the final one,
  // and whether it closes the message.
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [IDX_W-1:0]                 last_idx;
    logic                             msg_end;
  } work_t;

  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2,
    PHASE_X = 2'd3
  } phase_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] s);
    logic [CHAR_W-1:0] v;
    v = {1'b0, s};
    if (s < 6'd26) begin
      sextet_char = v + 7'd65;
    end else if (s < 6'd52) begin
      sextet_char = v + 7'd71;
    end else if (s < 6'd62) begin
      sextet_char = v - 7'd4;
    end else if (s == 6'd62) begin
      sextet_char = 7'd43;
    end else begin
      sextet_char = 7'd47;
    end
  endfunction

endpackage

// ===== design/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and builds character requests.
module b64e_front import b64e_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output work_t    q_data
);

  phase_t     group_phase, group_phase_next;
  logic [5:0] leftover_bits, leftover_bits_next;
  logic [7:0] b;

  assign b      = in_data.data_byte;
  assign q_push = push && !q_full;

  always_comb begin
    q_data             = '0;
    q_data.msg_end     = in_data.last_byte;
    group_phase_next   = group_phase;
    leftover_bits_next = leftover_bits;
    unique case (group_phase)
      PHASE_1: begin
        q_data.chars[0]    = sextet_char(leftover_bits | {2'b00, b[7:4]});
        leftover_bits_next = {b[3:0], 2'b00};
        group_phase_next   = PHASE_2;
        q_data.chars[1]    = sextet_char({b[3:0], 2'b00});
        q_data.chars[2]    = PAD_CHAR;
        q_data.last_idx    = in_data.last_byte ? IDX_W'(2) : IDX_W'(0);
      end
      PHASE_2: begin
        q_data.chars[0]    = sextet_char(leftover_bits | {4'b0000, b[7:6]});
        q_data.chars[1]    = sextet_char(b[5:0]);
        q_data.last_idx    = IDX_W'(1);
        leftover_bits_next = '0;
        group_phase_next   = PHASE_0;
      end
      // A corrupted phase starts a new group, like phase zero.
      PHASE_0, PHASE_X: begin
        q_data.chars[0]    = sextet_char(b[7:2]);
        leftover_bits_next = {b[1:0], 4'b0000};
        group_phase_next   = PHASE_1;
        q_data.chars[1]    = sextet_char({b[1:0], 4'b0000});
        q_data.chars[2]    = PAD_CHAR;
        q_data.chars[3]    = PAD_CHAR;
        q_data.last_idx    = in_data.last_byte ? IDX_W'(3) : IDX_W'(0);
      end
      default: ;
    endcase
    if (in_data.last_byte) begin
      group_phase_next   = PHASE_0;
      leftover_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= PHASE_0;
      leftover_bits <= '0;
    end else if (q_push) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule

// ===== design/b64e_queue.sv =====
// Short request queue between the front end and the character serializer.
module b64e_queue import b64e_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wr_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output work_t rd_data
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  work_t            entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(Q_DEPTH);
  assign empty   = count == '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("request written into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== design/b64e_back.sv =====
// Back end: an output register sends request characters one per cycle while pop is high.
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  work_t     q_data,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  logic             out_valid;
  logic [IDX_W-1:0] idx;
  logic             load;
  logic             at_end;

  assign load   = !q_empty && (!out_valid || pop);
  assign at_end = idx == q_data.last_idx;
  assign q_pop  = load && at_end;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_char  <= q_data.chars[idx];
      out_data.last_char <= q_data.msg_end && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/base64_encoder.sv =====
// Top level of the streaming Base64 encoder.
//
// Encodes a byte stream with the standard alphabet (A-Z a-z 0-9 + /). Each
// accepted byte yields one or two characters; a byte flagged as last also
// flushes the partial sextet and pads with '=' to a four-character boundary,
// so it can yield up to four characters, the final one flagged last_char.
// A byte is encoded in the cycle it is pushed and queued in a two-entry
// request queue; characters leave through an output register at one per
// cycle while pop is held and requests wait. The single character output
// port sets the sustained rate: three bytes inside a message yield four
// characters, and a byte that closes a message with padding yields up to
// four. full rises only while the queue holds two requests; empty is
// low whenever a character is on out_data.
module base64_encoder import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_data
);

  logic  q_push, q_pop, q_full, q_empty;
  work_t q_wr, q_rd;

  assign full = q_full;

  b64e_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr)
  );

  b64e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the streaming Base64 encoder: directed table, then random messages.
module tb;
  import b64e_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0]  dbyte;
    logic        last;
    int          nchars;
    logic [31:0] text;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_data = '0;
  logic      full;
  logic      empty;
  out_item_t out_data;

  phase_t     enc_phase;
  logic [5:0] enc_carry;
  out_item_t  fresh_chars[$];
  out_item_t  pending_chars[$];
  dir_row_t   dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int chars_checked = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  base64_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [5:0] s);
    int idx;
    idx = 63 - int'(s);
    return ALPHABET[8*idx +: CHAR_W];
  endfunction

  function automatic void add_char(input logic [CHAR_W-1:0] c);
    out_item_t o;
    o.out_char  = c;
    o.last_char = 1'b0;
    fresh_chars.push_back(o);
  endfunction

  // Works out the characters one byte produces and advances the group position.
  function automatic void encode_byte(input in_item_t it);
    logic [7:0] b;
    out_item_t  tail;
    b = it.data_byte;
    fresh_chars.delete();
    case (enc_phase)
      PHASE_1: begin
        add_char(sextet_to_ascii(enc_carry | {2'b00, b[7:4]}));
        enc_carry = {b[3:0], 2'b00};
        enc_phase = PHASE_2;
        if (it.last_byte) begin
          add_char(sextet_to_ascii(enc_carry));
          add_char(PAD_CHAR);
        end
      end
      PHASE_2: begin
        add_char(sextet_to_ascii(enc_carry | {4'b0000, b[7:6]}));
        add_char(sextet_to_ascii(b[5:0]));
        enc_carry = '0;
        enc_phase = PHASE_0;
      end
      default: begin
        // The unused phase value starts a new group just like phase 0.
        add_char(sextet_to_ascii(b[7:2]));
        enc_carry = {b[1:0], 4'b0000};
        enc_phase = PHASE_1;
        if (it.last_byte) begin
          add_char(sextet_to_ascii(enc_carry));
          add_char(PAD_CHAR);
          add_char(PAD_CHAR);
        end
      end
    endcase
    if (it.last_byte) begin
      tail = fresh_chars.pop_back();
      tail.last_char = 1'b1;
      fresh_chars.push_back(tail);
      enc_phase = PHASE_0;
      enc_carry = '0;
    end
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic l, input int n,
                                  input logic [31:0] t);
    dir_row_t r;
    r.dbyte  = d;
    r.last   = l;
    r.nchars = n;
    r.text   = t;
    dir_rows.push_back(r);
  endfunction

  function automatic void report_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s) at cycle %0d: expected char %0d last %0b, got char %0d last %0b",
               what, cycles, want.out_char, want.last_char, got.out_char, got.last_char);
    end
  endfunction

  function automatic void check_char(input out_item_t got);
    out_item_t want;
    if (pending_chars.size() == 0) begin
      report_mismatch("no character expected", '0, got);
    end else begin
      want = pending_chars.pop_front();
      chars_checked++;
      if (got.out_char !== want.out_char) begin
        report_mismatch("out_char", want, got);
      end
      if (got.last_char !== want.last_char) begin
        report_mismatch("last_char", want, got);
      end
    end
  endfunction

  // Offers one byte, optionally after a random gap. A nonzero nchars gives the
  // characters typed into the table; otherwise the prediction is used.
  task automatic send_byte(input in_item_t it, input int nchars, input logic [31:0] text);
    out_item_t o;
    int        i;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (full) @(negedge clk);
    // The request is taken at the coming edge.
    encode_byte(it);
    if (nchars == 0) begin
      foreach (fresh_chars[k]) pending_chars.push_back(fresh_chars[k]);
    end else begin
      for (i = 0; i < nchars; i++) begin
        o.out_char  = text[8*(nchars-1-i) +: CHAR_W];
        o.last_char = it.last_byte && (i == nchars - 1);
        pending_chars.push_back(o);
      end
    end
    bytes_sent++;
    if (it.last_byte) begin
      msgs_sent++;
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
      if (pop && !empty) begin
        check_char(out_data);
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    int       len;
    int       i;
    int       ph;
    int       target;
    enc_phase = PHASE_0;
    enc_carry = '0;

    add_row(8'h00, 1'b1, 4, "AA==");
    add_row(8'hFF, 1'b1, 4, "/w==");
    add_row(8'h4D, 1'b0, 1, "T");
    add_row(8'h61, 1'b0, 1, "W");
    add_row(8'h6E, 1'b1, 2, "Fu");
    add_row(8'h4D, 1'b0, 1, "T");
    add_row(8'h61, 1'b1, 3, "WE=");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b1, 3, "/8=");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b1, 2, "//");
    add_row(8'h00, 1'b0, 1, "A");
    add_row(8'h00, 1'b0, 1, "A");
    add_row(8'h00, 1'b1, 2, "AA");
    add_row(8'hFB, 1'b0, 0, '0);
    add_row(8'hEF, 1'b0, 0, '0);
    add_row(8'hBE, 1'b1, 0, '0);
    add_row(8'h80, 1'b0, 0, '0);
    add_row(8'h01, 1'b0, 0, '0);
    add_row(8'h7F, 1'b1, 0, '0);
    add_row(8'hA5, 1'b1, 0, '0);
    add_row(8'h5A, 1'b0, 0, '0);
    add_row(8'hC3, 1'b1, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 22;
    recv_idle_pct = 59;
    foreach (dir_rows[r]) begin
      it.data_byte = dir_rows[r].dbyte;
      it.last_byte = dir_rows[r].last;
      send_byte(it, dir_rows[r].nchars, dir_rows[r].text);
    end

    for (ph = 0; ph < 3; ph++) begin
      wait_drained();
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 22 : 0;
      // With no idling on either side, a long output hold-off fills the block.
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      target = bytes_sent + RANDOM_ITEMS / 3;
      while (bytes_sent < target) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        for (i = 0; i < len; i++) begin
          it.data_byte = 8'($urandom_range(255));
          it.last_byte = (i == len - 1);
          send_byte(it, 0, '0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Encoded %0d bytes in %0d messages and checked %0d characters.",
             bytes_sent, msgs_sent, chars_checked);
    $display("Run covered both stall mixes, a stall-free stretch, a long output hold-off "
             , "and drained pauses; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== base64_encoder.f =====
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_encoder.sv
tb/tb.sv
